// ===== sv/bfd_pkg.sv =====
package bfd_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 17;
	localparam int KEPT_W = 7;
	localparam int IDX_W  = 6;

	localparam logic [BYTE_W-1:0] HDR_B0  = 8'hFE;
	localparam logic [BYTE_W-1:0] HDR_B1  = 8'hDC;
	localparam logic [BYTE_W-1:0] HDR_B2  = 8'hBA;
	localparam logic [BYTE_W-1:0] TRAILER = 8'hEF;

	localparam int REQ_BIT = 6;

	localparam logic [POS_W-1:0] POS_TYPE    = 17'd3;
	localparam logic [POS_W-1:0] POS_OPCODE  = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd5;
	localparam logic [POS_W-1:0] FRAME_FIXED = 17'd8;
	localparam logic [POS_W-1:0] SEQ_OFF_REQ = 17'd7;
	localparam logic [POS_W-1:0] SEQ_OFF_MSG = 17'd8;
	localparam logic [POS_W-1:0] MIN_TOT_REQ = 17'd9;
	localparam logic [POS_W-1:0] MIN_TOT_MSG = 17'd10;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEAD,
		PH_BODY
	} phase_t;

	// good frame closed on this cycle
	typedef struct packed {
		logic              valid;
		logic [KEPT_W-1:0] kept;
		logic [BYTE_W-1:0] msg_type;
		logic [BYTE_W-1:0] msg_opcode;
		logic [BYTE_W-1:0] msg_sequence;
	} frame_done_t;

	// drain side status seen by the parser
	typedef struct packed {
		logic busy;
		logic out_full;
	} drain_stat_t;

endpackage

// ===== sv/bfd_ram.sv =====
module bfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/bfd_parser.sv =====
module bfd_parser #(
	parameter int MAX_PAYLOAD = bfd_pkg::MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bfd_pkg::BYTE_W-1:0] in_byte,
	input  bfd_pkg::drain_stat_t       stat,
	output bfd_pkg::frame_done_t       done,
	output logic                       ram_we,
	output logic [AW-1:0]              ram_waddr,
	output logic [bfd_pkg::BYTE_W-1:0] ram_wdata
);

	localparam logic [bfd_pkg::KEPT_W-1:0] MAX_KEPT = bfd_pkg::KEPT_W'(MAX_PAYLOAD);

	bfd_pkg::phase_t phase_q, phase_d;

	logic [15:0]                  recent_q;
	logic [bfd_pkg::POS_W-1:0]    pos_q;
	logic [bfd_pkg::POS_W-1:0]    total_q;
	logic [bfd_pkg::BYTE_W-1:0]   type_q;
	logic [bfd_pkg::BYTE_W-1:0]   opcode_q;
	logic [bfd_pkg::BYTE_W-1:0]   seq_q;
	logic [bfd_pkg::KEPT_W-1:0]   kept_q;
	logic                         over_q;

	logic                         accept;
	logic                         end_byte;
	logic                         hdr_hit;
	logic                         req;
	logic [bfd_pkg::POS_W-1:0]    seq_off;
	logic                         frame_ok;
	logic                         in_payload;

	assign accept = in_valid && !in_stall;

	// next state
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				bfd_pkg::PH_HEAD: begin
					if (pos_q != bfd_pkg::POS_TYPE && pos_q != bfd_pkg::POS_OPCODE &&
					    pos_q != bfd_pkg::POS_LEN_HI) begin
						phase_d = bfd_pkg::PH_BODY;
					end
				end
				bfd_pkg::PH_BODY: begin
					if (end_byte) begin
						phase_d = bfd_pkg::PH_HUNT;
					end
				end
				default: begin
					phase_d = hdr_hit ? bfd_pkg::PH_HEAD : bfd_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		req        = type_q[bfd_pkg::REQ_BIT];
		seq_off    = req ? bfd_pkg::SEQ_OFF_REQ : bfd_pkg::SEQ_OFF_MSG;
		end_byte   = (phase_q == bfd_pkg::PH_BODY) &&
		             ({1'b0, pos_q} + 18'd1 >= {1'b0, total_q});
		hdr_hit    = (recent_q == {bfd_pkg::HDR_B0, bfd_pkg::HDR_B1}) &&
		             (in_byte == bfd_pkg::HDR_B2);
		frame_ok   = (in_byte == bfd_pkg::TRAILER) && !over_q &&
		             (total_q >= (req ? bfd_pkg::MIN_TOT_REQ : bfd_pkg::MIN_TOT_MSG));
		in_payload = (phase_q == bfd_pkg::PH_BODY) && !end_byte && (pos_q > seq_off);

		// hold input while draining, and hold the closing byte until the output is free
		in_stall   = stat.busy || (end_byte && stat.out_full);

		ram_we     = accept && in_payload && (kept_q < MAX_KEPT);
		ram_waddr  = kept_q[AW-1:0];
		ram_wdata  = in_byte;

		done.valid        = accept && end_byte && frame_ok;
		done.kept         = kept_q;
		done.msg_type     = type_q;
		done.msg_opcode   = opcode_q;
		done.msg_sequence = seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bfd_pkg::PH_HUNT;
			recent_q <= '0;
			pos_q    <= '0;
			total_q  <= '0;
			type_q   <= '0;
			opcode_q <= '0;
			seq_q    <= '0;
			kept_q   <= '0;
			over_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				unique case (phase_q)
					bfd_pkg::PH_HEAD: begin
						if (pos_q == bfd_pkg::POS_TYPE) begin
							type_q <= in_byte;
						end else if (pos_q == bfd_pkg::POS_OPCODE) begin
							opcode_q <= in_byte;
						end else if (pos_q == bfd_pkg::POS_LEN_HI) begin
							total_q <= {1'b0, in_byte, 8'h00};
						end else begin
							total_q <= bfd_pkg::FRAME_FIXED + (total_q | {9'h000, in_byte});
						end
						pos_q <= pos_q + 17'd1;
					end
					bfd_pkg::PH_BODY: begin
						if (end_byte) begin
							recent_q <= '0;
							pos_q    <= '0;
						end else begin
							if (pos_q == seq_off) begin
								seq_q <= in_byte;
							end else if (in_payload) begin
								if (kept_q < MAX_KEPT) begin
									kept_q <= kept_q + 7'd1;
								end else begin
									over_q <= 1'b1;
								end
							end
							pos_q <= pos_q + 17'd1;
						end
					end
					default: begin
						if (hdr_hit) begin
							pos_q    <= bfd_pkg::POS_TYPE;
							total_q  <= '0;
							type_q   <= '0;
							opcode_q <= '0;
							seq_q    <= '0;
							kept_q   <= '0;
							over_q   <= 1'b0;
							recent_q <= '0;
						end else begin
							recent_q <= {recent_q[7:0], in_byte};
						end
					end
				endcase
			end
		end
	end

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (kept_q < MAX_KEPT && !over_q))
		else $error("payload write past store bound");

	a_head_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bfd_pkg::PH_HEAD) |-> (pos_q >= 17'd3 && pos_q <= 17'd6))
		else $error("header field position out of range");

	a_close_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_byte) |=> (phase_q == bfd_pkg::PH_HUNT && recent_q == 16'h0000))
		else $error("frame close did not restart hunting");

endmodule

// ===== sv/bfd_drain.sv =====
module bfd_drain #(
	parameter int MAX_PAYLOAD = bfd_pkg::MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bfd_pkg::frame_done_t       done,
	output bfd_pkg::drain_stat_t       stat,
	output logic                       ram_re,
	output logic [AW-1:0]              ram_raddr,
	input  logic [bfd_pkg::BYTE_W-1:0] ram_rdata,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bfd_pkg::BYTE_W-1:0] msg_type,
	output logic [bfd_pkg::BYTE_W-1:0] msg_opcode,
	output logic [bfd_pkg::BYTE_W-1:0] msg_sequence,
	output logic                       has_payload,
	output logic [bfd_pkg::BYTE_W-1:0] payload_byte,
	output logic [bfd_pkg::IDX_W-1:0]  payload_index,
	output logic                       last
);

	logic                          drain_q;
	logic [bfd_pkg::KEPT_W-1:0]    rd_idx_q;
	logic [bfd_pkg::KEPT_W-1:0]    cnt_q;
	logic [bfd_pkg::BYTE_W-1:0]    type_q;
	logic [bfd_pkg::BYTE_W-1:0]    opcode_q;
	logic [bfd_pkg::BYTE_W-1:0]    seq_q;

	logic                          rd_pend_s1;
	logic [bfd_pkg::KEPT_W-1:0]    rd_idx_s1;
	logic                          rd_last_s1;

	logic                          out_valid_q;
	logic [bfd_pkg::BYTE_W-1:0]    type_out_q;
	logic [bfd_pkg::BYTE_W-1:0]    opcode_out_q;
	logic [bfd_pkg::BYTE_W-1:0]    seq_out_q;
	logic                          has_q;
	logic [bfd_pkg::BYTE_W-1:0]    byte_q;
	logic [bfd_pkg::IDX_W-1:0]     index_q;
	logic                          last_q;

	logic                          take;
	logic                          load;
	logic                          issue;
	logic                          issue_last;

	always_comb begin
		take       = out_valid_q && !out_stall;
		// pending read data lands in the output word when that word is free
		load       = rd_pend_s1 && (!out_valid_q || !out_stall);
		issue      = drain_q && (!rd_pend_s1 || load);
		issue_last = (rd_idx_q + 7'd1) == cnt_q;
		ram_re     = issue;
		ram_raddr  = rd_idx_q[AW-1:0];
		stat.busy     = drain_q || rd_pend_s1;
		stat.out_full = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= 1'b0;
			rd_idx_q    <= '0;
			cnt_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done.valid && done.kept != '0) begin
				drain_q  <= 1'b1;
				rd_idx_q <= '0;
				cnt_q    <= done.kept;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + 7'd1;
				if (issue_last) begin
					drain_q <= 1'b0;
				end
			end

			if (issue) begin
				rd_pend_s1 <= 1'b1;
			end else if (load) begin
				rd_pend_s1 <= 1'b0;
			end

			if ((done.valid && done.kept == '0) || load) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done.valid) begin
			type_q   <= done.msg_type;
			opcode_q <= done.msg_opcode;
			seq_q    <= done.msg_sequence;
		end
		if (issue) begin
			rd_idx_s1  <= rd_idx_q;
			rd_last_s1 <= issue_last;
		end
		if (done.valid && done.kept == '0) begin
			type_out_q   <= done.msg_type;
			opcode_out_q <= done.msg_opcode;
			seq_out_q    <= done.msg_sequence;
			has_q        <= 1'b0;
			byte_q       <= '0;
			index_q      <= '0;
			last_q       <= 1'b1;
		end else if (load) begin
			type_out_q   <= type_q;
			opcode_out_q <= opcode_q;
			seq_out_q    <= seq_q;
			has_q        <= 1'b1;
			byte_q       <= ram_rdata;
			index_q      <= bfd_pkg::IDX_W'(rd_idx_s1);
			last_q       <= rd_last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign msg_type      = type_out_q;
	assign msg_opcode    = opcode_out_q;
	assign msg_sequence  = seq_out_q;
	assign has_payload   = has_q;
	assign payload_byte  = byte_q;
	assign payload_index = index_q;
	assign last          = last_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |-> (!drain_q && !rd_pend_s1 && !out_valid_q))
		else $error("frame closed while output side busy");

	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 && out_valid_q && out_stall) |=> (rd_pend_s1 && $stable(rd_idx_s1)))
		else $error("pending read lost under stall");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> !drain_q)
		else $error("last word shown while reads remain");

endmodule

// ===== sv/byte_frame_deframer.sv =====
// channel  | handshake            | words
// in       | in_valid / in_stall  | in_byte
// out      | out_valid / out_stall| msg_type, msg_opcode, msg_sequence, has_payload,
//          |                      | payload_byte, payload_index, last
//
// One input byte per cycle while parsing. A good frame with N stored payload bytes
// is drained from the payload RAM at one word per cycle while out_stall is low,
// through its registered read port; input is stalled for the drain.
// The closing byte of a frame is held while the output word is still full.
// Reset (arst_n low) returns to header hunting; the payload RAM is not cleared.
module byte_frame_deframer #(
	parameter int MAX_PAYLOAD = bfd_pkg::MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bfd_pkg::BYTE_W-1:0] in_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bfd_pkg::BYTE_W-1:0] msg_type,
	output logic [bfd_pkg::BYTE_W-1:0] msg_opcode,
	output logic [bfd_pkg::BYTE_W-1:0] msg_sequence,
	output logic                       has_payload,
	output logic [bfd_pkg::BYTE_W-1:0] payload_byte,
	output logic [bfd_pkg::IDX_W-1:0]  payload_index,
	output logic                       last
);

	bfd_pkg::frame_done_t       done;
	bfd_pkg::drain_stat_t       stat;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [bfd_pkg::BYTE_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [bfd_pkg::BYTE_W-1:0] ram_rdata;

	bfd_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.stat      (stat),
		.done      (done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	bfd_ram #(
		.WIDTH(bfd_pkg::BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfd_drain #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.done          (done),
		.stat          (stat),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.msg_type      (msg_type),
		.msg_opcode    (msg_opcode),
		.msg_sequence  (msg_sequence),
		.has_payload   (has_payload),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.last          (last)
	);

endmodule

// ===== tb/deframer_monitor.sv =====
`timescale 1ns / 100ps

module deframer_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [bfd_pkg::BYTE_W-1:0] in_byte,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [bfd_pkg::BYTE_W-1:0] msg_type,
	input  logic [bfd_pkg::BYTE_W-1:0] msg_opcode,
	input  logic [bfd_pkg::BYTE_W-1:0] msg_sequence,
	input  logic                       has_payload,
	input  logic [bfd_pkg::BYTE_W-1:0] payload_byte,
	input  logic [bfd_pkg::IDX_W-1:0]  payload_index,
	input  logic                       last,
	output int                         mismatches,
	output int                         pending,
	output int                         frames_released,
	output int                         words_seen
);

	typedef struct packed {
		logic [bfd_pkg::BYTE_W-1:0] mtype;
		logic [bfd_pkg::BYTE_W-1:0] opcode;
		logic [bfd_pkg::BYTE_W-1:0] seq;
		logic                       has_pl;
		logic [bfd_pkg::BYTE_W-1:0] pl_byte;
		logic [bfd_pkg::IDX_W-1:0]  pl_idx;
		logic                       is_last;
	} deframed_word_t;

	// parser state mirrored from the stream
	logic [2*bfd_pkg::BYTE_W-1:0] hunt_hist;
	bfd_pkg::phase_t              phase;
	logic [bfd_pkg::POS_W-1:0]    pos;
	logic [bfd_pkg::POS_W-1:0]    total;
	logic [bfd_pkg::BYTE_W-1:0]   f_type;
	logic [bfd_pkg::BYTE_W-1:0]   f_opcode;
	logic [bfd_pkg::BYTE_W-1:0]   f_seq;
	logic [bfd_pkg::BYTE_W-1:0]   pay_mem [bfd_pkg::MAX_PAYLOAD_DEF];
	logic [bfd_pkg::KEPT_W-1:0]   kept;
	logic                         too_long;

	deframed_word_t expected_words[$];

	function automatic string word_str(input deframed_word_t w);
		return $sformatf("type %02h op %02h seq %02h has %0b byte %02h idx %0d last %0b",
			w.mtype, w.opcode, w.seq, w.has_pl, w.pl_byte, w.pl_idx, w.is_last);
	endfunction

	task automatic release_word(input logic has, input logic [bfd_pkg::BYTE_W-1:0] b,
			input logic [bfd_pkg::IDX_W-1:0] idx, input logic fin);
		deframed_word_t w;
		w.mtype   = f_type;
		w.opcode  = f_opcode;
		w.seq     = f_seq;
		w.has_pl  = has;
		w.pl_byte = b;
		w.pl_idx  = idx;
		w.is_last = fin;
		expected_words.insert(expected_words.size(), w);
	endtask

	task automatic take_byte(input logic [bfd_pkg::BYTE_W-1:0] b);
		logic                      is_req;
		logic [bfd_pkg::POS_W-1:0] seq_pos;
		logic [bfd_pkg::POS_W-1:0] min_total;
		int                        i;
		case (phase)
			bfd_pkg::PH_HEAD: begin
				case (pos)
					bfd_pkg::POS_TYPE:   f_type = b;
					bfd_pkg::POS_OPCODE: f_opcode = b;
					bfd_pkg::POS_LEN_HI: total = bfd_pkg::POS_W'(b) << 8;
					default: begin
						total = bfd_pkg::FRAME_FIXED + (total | bfd_pkg::POS_W'(b));
						phase = bfd_pkg::PH_BODY;
					end
				endcase
				pos = pos + 1'b1;
			end
			bfd_pkg::PH_BODY: begin
				is_req    = f_type[bfd_pkg::REQ_BIT];
				seq_pos   = is_req ? bfd_pkg::SEQ_OFF_REQ : bfd_pkg::SEQ_OFF_MSG;
				min_total = is_req ? bfd_pkg::MIN_TOT_REQ : bfd_pkg::MIN_TOT_MSG;
				if (pos + 1'b1 >= total) begin
					// closing byte: release only a well-formed frame
					if (b == bfd_pkg::TRAILER && total >= min_total && !too_long) begin
						if (kept == '0)
							release_word(1'b0, '0, '0, 1'b1);
						else
							for (i = 0; i < int'(kept); i++)
								release_word(1'b1, pay_mem[i], bfd_pkg::IDX_W'(i),
									i + 1 == int'(kept));
					end
					phase     = bfd_pkg::PH_HUNT;
					hunt_hist = '0;
					pos       = '0;
				end else begin
					if (pos == seq_pos) begin
						f_seq = b;
					end else if (pos > seq_pos) begin
						if (int'(kept) < bfd_pkg::MAX_PAYLOAD_DEF) begin
							pay_mem[kept[bfd_pkg::IDX_W-1:0]] = b;
							kept = kept + 1'b1;
						end else begin
							too_long = 1'b1;
						end
					end
					pos = pos + 1'b1;
				end
			end
			default: begin
				if (hunt_hist == {bfd_pkg::HDR_B0, bfd_pkg::HDR_B1} &&
				    b == bfd_pkg::HDR_B2) begin
					phase     = bfd_pkg::PH_HEAD;
					pos       = bfd_pkg::POS_TYPE;
					total     = '0;
					f_type    = '0;
					f_opcode  = '0;
					f_seq     = '0;
					kept      = '0;
					too_long  = 1'b0;
					hunt_hist = '0;
				end else begin
					phase     = bfd_pkg::PH_HUNT;
					hunt_hist = {hunt_hist[bfd_pkg::BYTE_W-1:0], b};
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		deframed_word_t got;
		deframed_word_t want;
		if (!arst_n) begin
			hunt_hist = '0;
			phase     = bfd_pkg::PH_HUNT;
			pos       = '0;
			total     = '0;
			f_type    = '0;
			f_opcode  = '0;
			f_seq     = '0;
			kept      = '0;
			too_long  = 1'b0;
			expected_words.delete();
			mismatches      = 0;
			frames_released = 0;
			words_seen      = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {msg_type, msg_opcode, msg_sequence, has_payload, payload_byte,
					payload_index, last};
				words_seen++;
				if (got.is_last)
					frames_released++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: word mismatch", $realtime);
						$display("  expected no word");
						$display("  actual   %s", word_str(got));
					end
				end else begin
					want = expected_words.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: word mismatch", $realtime);
							$display("  expected %s", word_str(want));
							$display("  actual   %s", word_str(got));
						end
					end
				end
			end
			if (in_valid && !in_stall)
				take_byte(in_byte);
		end
		pending = expected_words.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

	typedef enum {FILL_RANDOM, FILL_HEADER, FILL_EXTREME} fill_t;

	localparam int LIMIT_NS = 400000;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic [bfd_pkg::BYTE_W-1:0] in_byte   = '0;
	logic                       out_stall = 1'b0;
	logic                       in_stall;
	logic                       out_valid;
	logic [bfd_pkg::BYTE_W-1:0] msg_type;
	logic [bfd_pkg::BYTE_W-1:0] msg_opcode;
	logic [bfd_pkg::BYTE_W-1:0] msg_sequence;
	logic                       has_payload;
	logic [bfd_pkg::BYTE_W-1:0] payload_byte;
	logic [bfd_pkg::IDX_W-1:0]  payload_index;
	logic                       last;

	int mismatches;
	int pending;
	int frames_released;
	int words_seen;

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int bytes_sent   = 0;

	logic [bfd_pkg::BYTE_W-1:0] stream[$];

	byte_frame_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.msg_type     (msg_type),
		.msg_opcode   (msg_opcode),
		.msg_sequence (msg_sequence),
		.has_payload  (has_payload),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.last         (last)
	);

	deframer_monitor i_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.msg_type       (msg_type),
		.msg_opcode     (msg_opcode),
		.msg_sequence   (msg_sequence),
		.has_payload    (has_payload),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.last           (last),
		.mismatches     (mismatches),
		.pending        (pending),
		.frames_released(frames_released),
		.words_seen     (words_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= $urandom_range(99) < recv_gap_pct;

	initial begin
		#LIMIT_NS;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int len_for(input logic [bfd_pkg::BYTE_W-1:0] ftype,
			input int n_payload);
		return n_payload + (ftype[bfd_pkg::REQ_BIT] ? 1 : 2);
	endfunction

	// append one byte to the outgoing stream
	task automatic queue_byte(input logic [bfd_pkg::BYTE_W-1:0] b);
		stream.insert(stream.size(), b);
	endtask

	// queue one frame of 8+len bytes; len is the raw length field
	task automatic add_frame(input logic [bfd_pkg::BYTE_W-1:0] ftype,
			input logic [bfd_pkg::BYTE_W-1:0] opcode, input logic [bfd_pkg::BYTE_W-1:0] seq,
			input int len, input logic [bfd_pkg::BYTE_W-1:0] trailer, input fill_t fill);
		int                         p;
		int                         seq_pos;
		logic [bfd_pkg::BYTE_W-1:0] b;
		logic [15:0]                len16;
		seq_pos = ftype[bfd_pkg::REQ_BIT] ? int'(bfd_pkg::SEQ_OFF_REQ) :
		                                    int'(bfd_pkg::SEQ_OFF_MSG);
		len16   = 16'(len);
		queue_byte(bfd_pkg::HDR_B0);
		queue_byte(bfd_pkg::HDR_B1);
		queue_byte(bfd_pkg::HDR_B2);
		queue_byte(ftype);
		queue_byte(opcode);
		queue_byte(len16[15:8]);
		queue_byte(len16[7:0]);
		// body runs from offset 7 up to the trailer at 7+len
		for (p = int'(bfd_pkg::SEQ_OFF_REQ); p < int'(bfd_pkg::SEQ_OFF_REQ) + len; p++) begin
			case (fill)
				FILL_HEADER:  b = (p % 3 == 0) ? bfd_pkg::HDR_B0 :
				                  (p % 3 == 1) ? bfd_pkg::HDR_B1 : bfd_pkg::HDR_B2;
				FILL_EXTREME: b = p[0] ? 8'hFF : 8'h00;
				default:      b = bfd_pkg::BYTE_W'($urandom);
			endcase
			if (p == seq_pos)
				b = seq;
			queue_byte(b);
		end
		queue_byte(trailer);
	endtask

	task automatic add_random(input int target);
		int                         r;
		int                         n;
		logic [bfd_pkg::BYTE_W-1:0] ftype;
		while (stream.size() < target) begin
			r     = $urandom_range(99);
			ftype = bfd_pkg::BYTE_W'($urandom);
			n     = ($urandom_range(9) == 0) ? $urandom_range(13, 66) : $urandom_range(0, 12);
			if (r < 80) begin
				add_frame(ftype, bfd_pkg::BYTE_W'($urandom), bfd_pkg::BYTE_W'($urandom),
					len_for(ftype, n), bfd_pkg::TRAILER, FILL_RANDOM);
			end else if (r < 87) begin
				add_frame(ftype, bfd_pkg::BYTE_W'($urandom), bfd_pkg::BYTE_W'($urandom),
					len_for(ftype, n), bfd_pkg::BYTE_W'($urandom), FILL_RANDOM);
			end else if (r < 93) begin
				repeat ($urandom_range(1, 6))
					queue_byte(bfd_pkg::BYTE_W'($urandom));
			end else if (r < 97) begin
				// broken header: header prefix then junk
				queue_byte(bfd_pkg::HDR_B0);
				queue_byte(bfd_pkg::HDR_B1);
				queue_byte(bfd_pkg::BYTE_W'($urandom));
			end else begin
				add_frame(ftype, bfd_pkg::BYTE_W'($urandom), bfd_pkg::BYTE_W'($urandom),
					$urandom_range(0, 1), bfd_pkg::TRAILER, FILL_RANDOM);
			end
		end
	endtask

	// hold each word until taken; idle between words at the current sender rate
	task automatic send_stream();
		while (stream.size() > 0) begin
			while ($urandom_range(99) < send_gap_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte  <= stream.pop_front();
			do
				@(posedge clk);
			while (in_stall);
			bytes_sent++;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 33;
		recv_gap_pct = 45;

		// stray bytes, then a header that overlaps a partial one
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(bfd_pkg::HDR_B0);
		queue_byte(bfd_pkg::HDR_B0);
		queue_byte(bfd_pkg::HDR_B1);
		add_frame(8'h40, 8'h00, 8'h11, 1, bfd_pkg::TRAILER, FILL_RANDOM);
		add_frame(8'h00, 8'hFF, 8'h22, 2, bfd_pkg::TRAILER, FILL_RANDOM);
		add_frame(8'h7F, 8'h01, 8'h33, 65, bfd_pkg::TRAILER, FILL_EXTREME);
		add_frame(8'hFF, 8'h5A, 8'h00, 4, bfd_pkg::TRAILER, FILL_HEADER);
		add_frame(8'h01, 8'h34, 8'h55, 0, bfd_pkg::TRAILER, FILL_RANDOM);
		add_frame(8'h40, 8'h56, 8'h66, 3, 8'hEE, FILL_RANDOM);
		add_frame(8'h02, 8'h78, 8'h67, 1, bfd_pkg::TRAILER, FILL_RANDOM);
		add_frame(8'h00, 8'hA5, 8'h77, 5, bfd_pkg::TRAILER, FILL_HEADER);
		add_frame(8'h40, 8'hC3, 8'h88, 2, bfd_pkg::TRAILER, FILL_EXTREME);
		add_frame(8'h03, 8'hE7, 8'h99, 67, bfd_pkg::TRAILER, FILL_RANDOM);
		queue_byte(bfd_pkg::HDR_B0);
		queue_byte(bfd_pkg::HDR_B1);
		queue_byte(8'h00);
		add_frame(8'h80, 8'h0F, 8'hAA, 3, bfd_pkg::TRAILER, FILL_EXTREME);
		send_stream();

		add_random(50);
		send_stream();

		send_gap_pct = 45;
		recv_gap_pct = 33;
		add_random(80);
		send_stream();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		add_random(80);
		send_stream();

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);

		$display("Stream of %0d bytes: directed frames, random traffic, three idle mixes.",
			bytes_sent);
		$display("Checked %0d output words from %0d released frames; %0d mismatches.",
			words_seen, frames_released, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== byte_frame_deframer.f =====
sv/bfd_pkg.sv
sv/bfd_ram.sv
sv/bfd_parser.sv
sv/bfd_drain.sv
sv/byte_frame_deframer.sv
tb/deframer_monitor.sv
tb/tb.sv
